// ----- hdl/twt_pkg.sv -----
// Package for the text word tokenizer: character codes, counter limits and
// the word record that travels from the front end to the output stage.
// No dependencies.
package twt_pkg;

  localparam int unsigned CNT_W        = 16;
  localparam int unsigned MAX_TEXT_LEN = 65536;
  localparam int unsigned QDEPTH       = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam logic MODE_CHAR = 1'b0;
  localparam logic MODE_END  = 1'b1;

  // Raw counter snapshot of one finished word; length and column are
  // derived from it in the output stage.
  typedef struct packed {
    logic [CNT_W-1:0] line;
    logic [CNT_W-1:0] column_count;
    logic [CNT_W-1:0] position;
    logic [CNT_W-1:0] start;
    logic             last;
  } word_rec_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
  endfunction

endpackage

// ----- hdl/twt_front.sv -----
// Front end of the tokenizer: classifies each item, keeps the line, column
// and position counters and produces one word record per word boundary and per end-of-text mark.
// Depends on twt_pkg.
module twt_front import twt_pkg::*; #(
  parameter int unsigned MAX_LEN = MAX_TEXT_LEN
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  logic      mode,
  input  logic [7:0] char_byte,
  output logic      push,
  output word_rec_t rec
);

  localparam int unsigned AW = $clog2(MAX_LEN + 1);

  logic [7:0]       previous_char;
  logic             previous_valid;
  logic [CNT_W-1:0] line_count;
  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] position_count;
  logic [CNT_W-1:0] word_start;
  logic [AW-1:0]    accepted;

  logic prev_blank, prev_nl, cur_blank, cur_nl, boundary, text_full;

  always_comb begin
    prev_blank = previous_valid && (previous_char == CH_SPACE || previous_char == CH_TAB);
    prev_nl    = previous_valid && (previous_char == CH_NEWLINE);
    cur_blank  = (char_byte == CH_SPACE) || (char_byte == CH_TAB);
    cur_nl     = (char_byte == CH_NEWLINE);
    boundary   = (!cur_blank && prev_blank) || prev_nl || cur_nl;
    text_full  = (accepted >= AW'(MAX_LEN));
  end

  assign push = accept && ((mode == MODE_END) || (!text_full && boundary && previous_valid));

  always_comb begin
    rec.line         = line_count;
    rec.column_count = column_count;
    rec.position     = position_count;
    rec.start        = word_start;
    rec.last         = (mode == MODE_END);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && mode == MODE_END)) begin
      previous_char  <= '0;
      previous_valid <= 1'b0;
      line_count     <= '0;
      column_count   <= '0;
      position_count <= '0;
      word_start     <= '0;
      accepted       <= '0;
    end else if (accept && !text_full) begin
      accepted <= accepted + AW'(1);
      if (boundary) begin
        word_start <= position_count;
      end
      if (prev_nl) begin
        line_count   <= sat_inc(line_count);
        column_count <= CNT_W'(1);
      end else begin
        column_count <= sat_inc(column_count);
      end
      position_count <= sat_inc(position_count);
      previous_char  <= char_byte;
      previous_valid <= 1'b1;
    end
  end

endmodule

// ----- hdl/twt_queue.sv -----
// Short register queue of word records between the front end and the
// output stage. Depends on twt_pkg.
module twt_queue import twt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  word_rec_t push_rec,
  input  logic      pop,
  output logic      full,
  output logic      head_valid,
  output word_rec_t head_rec
);

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  word_rec_t     mem [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_rec   = mem[rd_ptr];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QDEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- hdl/twt_back.sv -----
// Output stage of the tokenizer: turns a queued word record into length and
// start column and holds the result in the output register. Depends on twt_pkg.
module twt_back import twt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  word_rec_t          head_rec,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4*CNT_W-1:0] out_data,
  output logic               out_last
);

  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] col;

  always_comb begin
    len = (head_rec.position >= head_rec.start) ? head_rec.position - head_rec.start : '0;
    col = (head_rec.column_count >= len) ? head_rec.column_count - len : '0;
  end

  assign pop = head_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= {head_rec.start, len, col, head_rec.line};
      out_last <= head_rec.last;
    end
  end

endmodule

// ----- hdl/text_word_tokenizer_top.sv -----
// Text word tokenizer: one text byte or end-of-text mark per cycle in while
// the queue is not full, one word record out per word boundary or end of text.
// A word that an accepted item finishes passes through the queue and then the
// output register before it appears on the output.
// Synchronous active-high reset clears the counters, the queue and the output
// valid flag; end of text also returns the counters to reset state.
module text_word_tokenizer_top import twt_pkg::*; #(
  parameter int unsigned MAX_LEN = MAX_TEXT_LEN
) (
  input  logic               clk,
  input  logic               rst,
  // Input stream: one item is a text byte or an end-of-text mark.
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,  // char_byte[7:0]
  input  logic               s_tuser,  // mode: 0 = text byte, 1 = end of text
  // Output stream: one item per emitted word.
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [4*CNT_W-1:0] m_tdata,  // word_line, word_column, word_length, word_offset
  output logic               m_tlast   // final_word
);

  // The front end takes an item only when the queue has room for the word it
  // may finish, so no result is ever dropped. An item produces at most one
  // word, so one free slot is always enough.
  logic      q_full;
  logic      accept;
  logic      push;
  word_rec_t push_rec;
  logic      head_valid;
  word_rec_t head_rec;
  logic      pop;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  // Front end: classification and counters.
  twt_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .mode      (s_tuser),
    .char_byte (s_tdata),
    .push      (push),
    .rec       (push_rec)
  );

  // The queue decouples the front end from a stalled output; the front end
  // keeps taking bytes while a finished word waits on the output register.
  twt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_rec   (push_rec),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_rec   (head_rec)
  );

  // Back end: derives length and column, then registers the result.
  twt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata),
    .out_last   (m_tlast)
  );

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Testbench for text_word_tokenizer_top: a directed table and random texts,
// each word checked against a local tokenizer model.
// Depends on twt_pkg and text_word_tokenizer_top.
module tb;
  import twt_pkg::*;

  // The cycle limit lies far above what the items need, so this only trips on
  // a hang.
  localparam int unsigned CYCLE_LIMIT  = 100_000;
  localparam int unsigned RANDOM_ITEMS = 1680;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned PLAN_ROWS    = 23;

  // Byte mixes for generated text.
  localparam int unsigned TXT_MIXED    = 0;
  localparam int unsigned TXT_NEWLINES = 1;
  localparam int unsigned TXT_ONE_LINE = 2;

  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_X = 8'h78;
  localparam logic [7:0] CH_Z = 8'h7A;

  // One emitted word; the low 64 bits line up with m_tdata, the top bit with m_tlast.
  typedef struct packed {
    logic             last;
    logic [CNT_W-1:0] offset;
    logic [CNT_W-1:0] length;
    logic [CNT_W-1:0] column;
    logic [CNT_W-1:0] line;
  } word_t;

  // One row of the directed table. When typed is set, want is the word the
  // row must produce and replaces the model's prediction.
  typedef struct packed {
    logic       md;
    logic [7:0] ch;
    logic       typed;
    word_t      want;
  } plan_row_t;

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [7:0]         s_tdata;
  logic               s_tuser;
  logic               m_tvalid;
  logic               m_tready;
  logic [4*CNT_W-1:0] m_tdata;
  logic               m_tlast;

  text_word_tokenizer_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  word_t       pending_words[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;

  // Sender burst shaping; changed per text.
  int unsigned burst_left = 0;
  int unsigned burst_max  = 8;
  int unsigned gap_max    = 3;

  // Tokenizer state as the block should hold it.
  logic [7:0]  prev_ch;
  bit          prev_ok;
  int unsigned line_n;
  int unsigned col_n;
  int unsigned pos_n;
  int unsigned start_n;
  int unsigned taken;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned bump(input int unsigned v);
    return (v >= CNT_MAX) ? CNT_MAX : v + 1;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  function automatic void clear_text();
    prev_ch = 8'h00;
    prev_ok = 1'b0;
    line_n  = 0;
    col_n   = 0;
    pos_n   = 0;
    start_n = 0;
    taken   = 0;
  endfunction

  function automatic word_t word_of(input int unsigned ln, input int unsigned col,
                                    input int unsigned len, input int unsigned off,
                                    input bit last);
    word_t w;
    w.line   = ln[CNT_W-1:0];
    w.column = col[CNT_W-1:0];
    w.length = len[CNT_W-1:0];
    w.offset = off[CNT_W-1:0];
    w.last   = last;
    return w;
  endfunction

  // The word that is open right now. The column clamps at zero should
  // saturated counters ever leave the column below the length.
  function automatic word_t open_word(input bit last);
    int unsigned len;
    int unsigned col;
    len = (pos_n >= start_n) ? pos_n - start_n : 0;
    col = (col_n >= len) ? col_n - len : 0;
    return word_of(line_n, col, len, start_n, last);
  endfunction

  // Advances the tokenizer by one item; returns 1 and the finished word when
  // the item closes one.
  function automatic bit tokenize_item(input logic md, input logic [7:0] ch,
                                       output word_t w);
    bit prev_blank;
    bit prev_nl;
    bit split;
    bit made;
    made = 1'b0;
    w    = '0;
    if (md == MODE_END) begin
      w = open_word(1'b1);
      clear_text();
      return 1'b1;
    end
    // Bytes beyond the maximum text length are dropped silently.
    if (taken >= MAX_TEXT_LEN) return 1'b0;
    taken++;
    prev_blank = prev_ok && is_blank(prev_ch);
    prev_nl    = prev_ok && prev_ch == CH_NEWLINE;
    split      = (!is_blank(ch) && prev_blank) || prev_nl || ch == CH_NEWLINE;
    if (split) begin
      if (prev_ok) begin
        w    = open_word(1'b0);
        made = 1'b1;
      end
      start_n = pos_n;
    end
    if (prev_nl) begin
      line_n = bump(line_n);
      col_n  = 1;
    end else begin
      col_n = bump(col_n);
    end
    pos_n   = bump(pos_n);
    prev_ch = ch;
    prev_ok = 1'b1;
    return made;
  endfunction

  function automatic logic [7:0] text_char(input int unsigned mix);
    int unsigned r;
    if (mix == TXT_NEWLINES) return CH_NEWLINE;
    r = $urandom_range(0, 99);
    if (r < 30) return 8'($urandom_range(CH_A, CH_Z));
    if (r < 45) return CH_SPACE;
    if (r < 55) return CH_TAB;
    if (r < 67 && mix == TXT_MIXED) return CH_NEWLINE;
    r = $urandom_range(0, 255);
    if (mix == TXT_ONE_LINE && r == CH_NEWLINE) return CH_SPACE;
    return 8'(r);
  endfunction

  // Presents one item, starting at a falling edge, and returns at the falling
  // edge after it is taken. Valid stays high inside a burst; a gap is only
  // opened when a burst runs out, so valid never drops and rises in one step.
  task automatic send_item(input logic md, input logic [7:0] ch, input bit typed,
                           input word_t want);
    word_t       w;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, burst_max);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= md;
    s_tdata  <= ch;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (tokenize_item(md, ch, w)) pending_words.push_back(typed ? want : w);
    @(negedge clk);
  endtask

  task automatic send_bytes(input int unsigned len, input int unsigned mix);
    for (int unsigned i = 0; i < len; i++) send_item(MODE_CHAR, text_char(mix), 1'b0, '0);
  endtask

  task automatic pick_burst_shape();
    case ($urandom_range(0, 3))
      0: begin burst_max = 1;  gap_max = 4; end
      1: begin burst_max = 6;  gap_max = 2; end
      2: begin burst_max = 40; gap_max = 1; end
      default: begin burst_max = 200; gap_max = 0; end
    endcase
  endtask

  // Receiver: each stretch of cycles follows one style, from always ready to
  // mostly stalled to strict alternation, so stalls land on every phase.
  initial begin : receiver
    int unsigned stall_style;
    int unsigned stall_left;
    m_tready    = 1'b0;
    stall_style = 0;
    stall_left  = 0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        stall_style = $urandom_range(0, 3);
        stall_left  = $urandom_range(8, 120);
      end
      stall_left--;
      case (stall_style)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= ~m_tready;
      endcase
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Every accepted word is matched against the oldest expected one.
  always @(posedge clk) begin : word_check
    word_t got;
    word_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tlast, m_tdata};
      if (pending_words.size() == 0) begin
        $error("word with nothing expected: line %0d offset %0d", got.line, got.offset);
        errors++;
      end else begin
        want = pending_words.pop_front();
        check_field("word_line", want.line, got.line);
        check_field("word_column", want.column, got.column);
        check_field("word_length", want.length, got.length);
        check_field("word_offset", want.offset, got.offset);
        check_field("final_word", want.last, got.last);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t   plan [PLAN_ROWS];
    word_t       none;
    int unsigned sent;
    int unsigned len;
    int unsigned mix;
    none     = '0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tuser  = MODE_CHAR;
    s_tdata  = 8'h00;
    clear_text();

    // Directed table: empty text right after reset, a word that keeps its
    // trailing space and tab, newlines as words of their own, a byte that
    // follows a newline, end of text with a byte that must be ignored,
    // leading blanks, a text that is just a newline, and extreme byte values.
    plan = '{
      '{MODE_END,  8'h00,      1'b1, word_of(0, 0, 0, 0, 1)},
      '{MODE_CHAR, CH_A,       1'b0, none},
      '{MODE_CHAR, CH_SPACE,   1'b0, none},
      '{MODE_CHAR, CH_TAB,     1'b0, none},
      '{MODE_CHAR, CH_B,       1'b1, word_of(0, 0, 3, 0, 0)},
      '{MODE_CHAR, CH_NEWLINE, 1'b1, word_of(0, 3, 1, 3, 0)},
      '{MODE_CHAR, CH_NEWLINE, 1'b0, none},
      '{MODE_CHAR, 8'h00,      1'b0, none},
      '{MODE_CHAR, 8'hFF,      1'b0, none},
      '{MODE_END,  8'hFF,      1'b0, none},
      '{MODE_END,  8'h00,      1'b1, word_of(0, 0, 0, 0, 1)},
      '{MODE_CHAR, CH_SPACE,   1'b0, none},
      '{MODE_CHAR, CH_SPACE,   1'b0, none},
      '{MODE_CHAR, CH_X,       1'b0, none},
      '{MODE_CHAR, CH_TAB,     1'b0, none},
      '{MODE_CHAR, CH_NEWLINE, 1'b0, none},
      '{MODE_CHAR, CH_SPACE,   1'b0, none},
      '{MODE_END,  CH_NEWLINE, 1'b0, none},
      '{MODE_CHAR, CH_NEWLINE, 1'b0, none},
      '{MODE_END,  8'h55,      1'b0, none},
      '{MODE_CHAR, 8'h7F,      1'b0, none},
      '{MODE_CHAR, 8'h80,      1'b0, none},
      '{MODE_END,  8'hAA,      1'b0, none}
    };

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) send_item(plan[i].md, plan[i].ch, plan[i].typed, plan[i].want);

    // Random texts, mostly short, some empty, a few longer; now and then a
    // text of nothing but newlines or one with no newline at all.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick_burst_shape();
      case ($urandom_range(0, 9))
        0: len = 0;
        8: len = $urandom_range(13, 60);
        9: len = $urandom_range(1, 4);
        default: len = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 7))
        0: mix = TXT_NEWLINES;
        1: mix = TXT_ONE_LINE;
        default: mix = TXT_MIXED;
      endcase
      send_bytes(len, mix);
      send_item(MODE_END, 8'($urandom), 1'b0, none);
      sent += len + 1;
    end
    s_tvalid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/twt_pkg.sv
hdl/twt_front.sv
hdl/twt_queue.sv
hdl/twt_back.sv
hdl/text_word_tokenizer_top.sv
test/tb.sv
